// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the RTL file that carries checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/hogc_pkg.sv
// ----------------------------------------------------------------------------
// hogc_pkg
// Types, constants and the reciprocal divide helper of the cell histogram.
// ----------------------------------------------------------------------------
package hogc_pkg;

   localparam int unsigned BINS      = 9;
   localparam int unsigned DEG180    = 23040;
   localparam int unsigned SPAN      = 23040;
   localparam int unsigned HALF      = SPAN / 2;
   localparam int unsigned TOP       = BINS * SPAN;

   // SPAN = 512 * 45: a power-of-two shift followed by a divide by 45.
   localparam int unsigned SHIFT_DIV = 9;
   localparam int unsigned ODD_DIV   = SPAN >> SHIFT_DIV;
   localparam logic [31:0] RECIP     = 32'((64'd1 << 32) / ODD_DIV);

   localparam int unsigned ANG_W     = $clog2(DEG180 + 1);
   localparam int unsigned A_W       = $clog2(TOP + 1);
   localparam int unsigned X_W       = A_W - SHIFT_DIV;
   localparam int unsigned BIN_W     = $clog2(BINS);
   localparam int unsigned W_W       = $clog2(SPAN + 1);
   localparam int unsigned MAG_W     = 16;
   localparam int unsigned PROD_W    = MAG_W + W_W;
   localparam int unsigned XS_W      = PROD_W - SHIFT_DIV;
   localparam int unsigned SHARE_W   = MAG_W;
   localparam int unsigned SUM_W     = 24;
   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   typedef struct packed {
      logic [15:0] angle_deg;
      logic [15:0] magnitude;
      logic        last_in_cell;
   } req_type;

   typedef struct packed {
      logic [3:0]  bin_number;
      logic [23:0] bin_sum;
      logic        final_bin;
   } rsp_type;

   // Bin index and the two interpolation weights of one pixel.
   typedef struct packed {
      logic             vld;
      logic             last;
      logic [MAG_W-1:0] mag;
      logic [BIN_W-1:0] bin;
      logic [W_W-1:0]   w0;
      logic [W_W-1:0]   w1;
   } weight_type;

   // Shares to add into bin and bin+1.
   typedef struct packed {
      logic               vld;
      logic               last;
      logic [BIN_W-1:0]   bin;
      logic [SHARE_W-1:0] s0;
      logic [SHARE_W-1:0] s1;
   } bin_update_type;

   // Estimate of x / ODD_DIV; it is either exact or one too small.
   function automatic logic [31:0] div_odd_est(input logic [31:0] x);
      logic [63:0] prod;
      prod = 64'(x) * 64'(RECIP);
      return prod[63:32];
   endfunction

endpackage

// File: hdl/hogc_weight_pipe.sv
// ----------------------------------------------------------------------------
// hogc_weight_pipe
// Input register, angle folding and scaling, bin search and weight selection.
// ----------------------------------------------------------------------------
module hogc_weight_pipe (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   req_valid,
   input  hogc_pkg::req_type      req_data,
   output hogc_pkg::weight_type   wgt
);
   import hogc_pkg::*;

   // Input register.
   logic                a_vld_ff;
   req_type             a_req_ff;

   // Folded and scaled angle.
   logic [15:0]         b_ang_sub;
   logic [ANG_W-1:0]    b_fold;
   logic [A_W-1:0]      b_a_in;
   logic                b_vld_ff;
   logic [A_W-1:0]      b_a_ff;
   logic [MAG_W-1:0]    b_mag_ff;
   logic                b_last_ff;

   // Region and bin estimate.
   logic [A_W-1:0]      c_p;
   logic [X_W-1:0]      c_kest_in;
   logic                c_low_in;
   logic                c_high_in;
   logic                c_vld_ff;
   logic [A_W-1:0]      c_a_ff;
   logic [X_W-1:0]      c_kest_ff;
   logic                c_low_ff;
   logic                c_high_ff;
   logic [MAG_W-1:0]    c_mag_ff;
   logic                c_last_ff;

   // Bin correction and weights.
   logic [A_W-1:0]      d_p;
   logic [X_W-1:0]      d_x;
   logic [X_W-1:0]      d_r;
   logic                d_corr;
   logic [X_W-1:0]      d_rf;
   logic [X_W-1:0]      d_k;
   logic [W_W-1:0]      d_f;
   logic [BIN_W-1:0]    d_bin_in;
   logic [W_W-1:0]      d_w0_in;
   logic [W_W-1:0]      d_w1_in;
   logic                d_vld_ff;
   logic                d_last_ff;
   logic [MAG_W-1:0]    d_mag_ff;
   logic [BIN_W-1:0]    d_bin_ff;
   logic [W_W-1:0]      d_w0_ff;
   logic [W_W-1:0]      d_w1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_valid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
      end
   end

   // Fold once by 180 degrees, then clamp anything still above 180.
   always_comb begin
      b_ang_sub = a_req_ff.angle_deg;
      if (b_ang_sub > 16'(DEG180)) begin
         b_ang_sub = b_ang_sub - 16'(DEG180);
      end
      if (b_ang_sub > 16'(DEG180)) begin
         b_fold = ANG_W'(DEG180);
      end else begin
         b_fold = ANG_W'(b_ang_sub);
      end
      b_a_in = A_W'(32'(b_fold) * 32'(BINS));
   end

   // The estimate is meaningful only in the middle region.
   assign c_p       = b_a_ff - A_W'(HALF);
   assign c_kest_in = X_W'(div_odd_est(32'(c_p[A_W-1:SHIFT_DIV])));
   assign c_low_in  = (b_a_ff <= A_W'(HALF));
   assign c_high_in = (b_a_ff >= A_W'(TOP - HALF));

   always_comb begin
      d_p    = c_a_ff - A_W'(HALF);
      d_x    = d_p[A_W-1:SHIFT_DIV];
      d_r    = d_x - X_W'(32'(c_kest_ff) * 32'(ODD_DIV));
      d_corr = (d_r >= X_W'(ODD_DIV));
      d_rf   = d_corr ? (d_r - X_W'(ODD_DIV)) : d_r;
      d_k    = c_kest_ff + X_W'(d_corr);
      d_f    = W_W'({d_rf, d_p[SHIFT_DIV-1:0]});
      if (c_low_ff) begin
         d_bin_in = '0;
         d_w0_in  = W_W'(32'(c_a_ff) + 32'(HALF));
         d_w1_in  = '0;
      end else if (c_high_ff) begin
         d_bin_in = BIN_W'(BINS - 1);
         d_w0_in  = W_W'(32'(TOP) + 32'(HALF) - 32'(c_a_ff));
         d_w1_in  = '0;
      end else begin
         d_bin_in = BIN_W'(d_k);
         d_w0_in  = W_W'(SPAN) - d_f;
         d_w1_in  = d_f;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_req_ff  <= req_data;
         b_a_ff    <= b_a_in;
         b_mag_ff  <= a_req_ff.magnitude;
         b_last_ff <= a_req_ff.last_in_cell;
         c_a_ff    <= b_a_ff;
         c_kest_ff <= c_kest_in;
         c_low_ff  <= c_low_in;
         c_high_ff <= c_high_in;
         c_mag_ff  <= b_mag_ff;
         c_last_ff <= b_last_ff;
         d_last_ff <= c_last_ff;
         d_mag_ff  <= c_mag_ff;
         d_bin_ff  <= d_bin_in;
         d_w0_ff   <= d_w0_in;
         d_w1_ff   <= d_w1_in;
      end
   end

   assign wgt.vld  = d_vld_ff;
   assign wgt.last = d_last_ff;
   assign wgt.mag  = d_mag_ff;
   assign wgt.bin  = d_bin_ff;
   assign wgt.w0   = d_w0_ff;
   assign wgt.w1   = d_w1_ff;

endmodule

// File: hdl/hogc_share_pipe.sv
// ----------------------------------------------------------------------------
// hogc_share_pipe
// Weighted magnitude products and their division by one span.
// ----------------------------------------------------------------------------
module hogc_share_pipe (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  hogc_pkg::weight_type       wgt,
   output hogc_pkg::bin_update_type   upd
);
   import hogc_pkg::*;

   logic [PROD_W-1:0]  e_prod0_in;
   logic [PROD_W-1:0]  e_prod1_in;
   logic               e_vld_ff;
   logic               e_last_ff;
   logic [BIN_W-1:0]   e_bin_ff;
   logic [PROD_W-1:0]  e_prod0_ff;
   logic [PROD_W-1:0]  e_prod1_ff;

   logic [XS_W-1:0]    f_x0;
   logic [XS_W-1:0]    f_x1;
   logic [SHARE_W-1:0] f_est0_in;
   logic [SHARE_W-1:0] f_est1_in;
   logic               f_vld_ff;
   logic               f_last_ff;
   logic [BIN_W-1:0]   f_bin_ff;
   logic [XS_W-1:0]    f_x0_ff;
   logic [XS_W-1:0]    f_x1_ff;
   logic [SHARE_W-1:0] f_est0_ff;
   logic [SHARE_W-1:0] f_est1_ff;

   logic [XS_W-1:0]    g_r0;
   logic [XS_W-1:0]    g_r1;
   logic [SHARE_W-1:0] g_s0_in;
   logic [SHARE_W-1:0] g_s1_in;
   logic               g_vld_ff;
   logic               g_last_ff;
   logic [BIN_W-1:0]   g_bin_ff;
   logic [SHARE_W-1:0] g_s0_ff;
   logic [SHARE_W-1:0] g_s1_ff;

   assign e_prod0_in = PROD_W'(32'(wgt.mag) * 32'(wgt.w0));
   assign e_prod1_in = PROD_W'(32'(wgt.mag) * 32'(wgt.w1));

   assign f_x0      = e_prod0_ff[PROD_W-1:SHIFT_DIV];
   assign f_x1      = e_prod1_ff[PROD_W-1:SHIFT_DIV];
   assign f_est0_in = SHARE_W'(div_odd_est(32'(f_x0)));
   assign f_est1_in = SHARE_W'(div_odd_est(32'(f_x1)));

   // One correction step brings each estimate to the exact quotient.
   assign g_r0    = f_x0_ff - XS_W'(32'(f_est0_ff) * 32'(ODD_DIV));
   assign g_r1    = f_x1_ff - XS_W'(32'(f_est1_ff) * 32'(ODD_DIV));
   assign g_s0_in = f_est0_ff + SHARE_W'(g_r0 >= XS_W'(ODD_DIV));
   assign g_s1_in = f_est1_ff + SHARE_W'(g_r1 >= XS_W'(ODD_DIV));

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
         f_vld_ff <= 1'b0;
         g_vld_ff <= 1'b0;
      end else if (adv) begin
         e_vld_ff <= wgt.vld;
         f_vld_ff <= e_vld_ff;
         g_vld_ff <= f_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_last_ff  <= wgt.last;
         e_bin_ff   <= wgt.bin;
         e_prod0_ff <= e_prod0_in;
         e_prod1_ff <= e_prod1_in;
         f_last_ff  <= e_last_ff;
         f_bin_ff   <= e_bin_ff;
         f_x0_ff    <= f_x0;
         f_x1_ff    <= f_x1;
         f_est0_ff  <= f_est0_in;
         f_est1_ff  <= f_est1_in;
         g_last_ff  <= f_last_ff;
         g_bin_ff   <= f_bin_ff;
         g_s0_ff    <= g_s0_in;
         g_s1_ff    <= g_s1_in;
      end
   end

   assign upd.vld  = g_vld_ff;
   assign upd.last = g_last_ff;
   assign upd.bin  = g_bin_ff;
   assign upd.s0   = g_s0_ff;
   assign upd.s1   = g_s1_ff;

endmodule

// File: hdl/hogc_accum.sv
// ----------------------------------------------------------------------------
// hogc_accum
// Saturating bin sums; the output bank drains a bin a cycle unless stalled.
// ----------------------------------------------------------------------------
module hogc_accum (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  hogc_pkg::bin_update_type   upd,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output hogc_pkg::rsp_type          rsp_data
);
   import hogc_pkg::*;

   logic [SUM_W-1:0] acc_ff   [BINS];
   logic [SUM_W-1:0] acc_in   [BINS];
   logic [SUM_W-1:0] bank_ff  [BINS];
   logic             busy_ff;
   logic [BIN_W-1:0] cnt_ff;
   logic [BIN_W:0]   bin1;
   logic             take;
   logic             load;
   logic             xfer;
   logic             final_bin;

   assign bin1      = {1'b0, upd.bin} + (BIN_W+1)'(1);
   assign take      = adv & upd.vld;
   assign load      = take & upd.last;
   assign xfer      = busy_ff & ~rsp_stall;
   assign final_bin = (cnt_ff == BIN_W'(BINS - 1));

   always_comb begin
      logic [SUM_W+1:0] sum;
      for (int i = 0; i < BINS; i++) begin
         sum = (SUM_W+2)'(acc_ff[i]);
         if (upd.bin == BIN_W'(i)) begin
            sum = sum + (SUM_W+2)'(upd.s0);
         end
         if (bin1 == (BIN_W+1)'(i)) begin
            sum = sum + (SUM_W+2)'(upd.s1);
         end
         acc_in[i] = (sum > (SUM_W+2)'(SUM_MAX)) ? SUM_MAX : sum[SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BINS; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (take) begin
         for (int i = 0; i < BINS; i++) begin
            acc_ff[i] <= upd.last ? '0 : acc_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (xfer) begin
         if (final_bin) begin
            busy_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff + BIN_W'(1);
         end
      end
   end

   // The bank shifts toward entry zero, which always faces the output.
   always_ff @(posedge clock) begin
      if (load) begin
         bank_ff <= acc_in;
      end else if (xfer) begin
         for (int i = 0; i < BINS - 1; i++) begin
            bank_ff[i] <= bank_ff[i+1];
         end
      end
   end

   assign rsp_valid           = busy_ff;
   assign rsp_data.bin_number = 4'(cnt_ff);
   assign rsp_data.bin_sum    = bank_ff[0];
   assign rsp_data.final_bin  = final_bin;

endmodule

// File: hdl/oriented_gradient_cell_histogram.sv
// ----------------------------------------------------------------------------
// oriented_gradient_cell_histogram - orientation histogram of one image cell.
// The closing pixel crosses the weight and share pipes into the bank; then
// a bin per cycle unless rsp_stall. One pixel per cycle, stalled only while
// a closing pixel waits for the prior drain. Reset clears valids, sums, drain.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module oriented_gradient_cell_histogram (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  hogc_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output hogc_pkg::rsp_type     rsp_data
);
   import hogc_pkg::*;

   // The whole pixel pipeline moves in lock step. It halts only when the
   // pixel closing a cell reaches the accumulators while the output bank is
   // still draining the previous cell; the halt is decided from registers
   // alone, so there is no combinational path from rsp_stall to req_stall.
   logic           hold;
   logic           adv;
   weight_type     wgt;
   bin_update_type upd;

   assign hold      = upd.vld & upd.last & rsp_valid;
   assign adv       = ~hold;
   assign req_stall = hold;

   // Input register, fold of the angle into 0..180 degrees, scaling by the
   // bin count, and the search for the lower neighbouring bin centre. The
   // divide by one span is a shift by 9 bits and a reciprocal multiply by 1/45
   // with a single correction step.
   hogc_weight_pipe u_weight (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .req_valid (req_valid),
      .req_data  (req_data),
      .wgt       (wgt)
   );

   // Magnitude times each weight, then the same exact divide by one span to
   // give the two shares; the remainders are dropped.
   hogc_share_pipe u_share (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .wgt   (wgt),
      .upd   (upd)
   );

   // Saturating accumulation of both shares in the same cycle. On the closing
   // pixel the updated sums move into the output bank and the accumulators
   // restart from zero, so the next cell can stream in without a gap.
   hogc_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .upd       (upd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Input is held back only while a histogram is being drained.
   `ASSERT_IMPLY(a_stall_while_draining, clock, reset, req_stall, rsp_valid,
                 "stall without drain")

   // The final bin's transfer ends the drain.
   `ASSERT_NEXT(a_drain_ends, clock, reset,
                rsp_valid && !rsp_stall && rsp_data.final_bin, !rsp_valid,
                "drain did not end")

   // Bins leave in ascending order with no gap.
   `ASSERT_NEXT(a_bin_order, clock, reset,
                rsp_valid && !rsp_stall && !rsp_data.final_bin,
                rsp_valid && (rsp_data.bin_number == $past(rsp_data.bin_number) + 4'd1),
                "bin order broken")

endmodule

// File: tb/sv/hog_bin_checker.sv
// ----------------------------------------------------------------------------
// hog_bin_checker
// Watches the pixel and bin channels of the cell histogram. It keeps its own
// bin totals and compares every emitted bin with the predicted one.
// ----------------------------------------------------------------------------
module hog_bin_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  hogc_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  hogc_pkg::rsp_type rsp_data,
   output int                mismatches,
   output int                bins_waiting
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef longint unsigned u64_t;

   // Angles are scaled by the bin count, so one bin span is 180 degrees in Q7.
   localparam int unsigned NBINS     = hogc_pkg::BINS;
   localparam int unsigned DEG180_Q7 = 23040;
   localparam int unsigned UNIT_SPAN = 23040;
   localparam int unsigned UNIT_HALF = UNIT_SPAN / 2;
   localparam int unsigned UNIT_TOP  = NBINS * UNIT_SPAN;
   localparam u64_t        SUM_CEIL  = 64'hFF_FFFF;

   logic [23:0]       bin_totals [NBINS];
   hogc_pkg::rsp_type expected_bins [$];

   function automatic void add_share(int unsigned bin, logic [15:0] mag,
                                     int unsigned weight);
      u64_t share;
      u64_t total;
      share = (u64_t'(mag) * u64_t'(weight)) / UNIT_SPAN;
      total = u64_t'(bin_totals[bin]) + share;
      bin_totals[bin] = (total > SUM_CEIL) ? 24'hFF_FFFF : total[23:0];
   endfunction

   function automatic void predict_pixel(hogc_pkg::req_type px);
      int unsigned       ang;
      int unsigned       scaled;
      int unsigned       offs;
      int unsigned       k;
      int unsigned       frac;
      hogc_pkg::rsp_type bin_out;
      ang = px.angle_deg;
      if (ang > DEG180_Q7) ang = ang - DEG180_Q7;
      if (ang > DEG180_Q7) ang = DEG180_Q7;
      scaled = ang * NBINS;
      if (scaled <= UNIT_HALF) begin
         add_share(0, px.magnitude, scaled + UNIT_HALF);
      end else if (scaled < UNIT_TOP - UNIT_HALF) begin
         offs = scaled - UNIT_HALF;
         k    = offs / UNIT_SPAN;
         if (k > NBINS - 2) k = NBINS - 2;
         frac = offs - k * UNIT_SPAN;
         add_share(k, px.magnitude, UNIT_SPAN - frac);
         add_share(k + 1, px.magnitude, frac);
      end else begin
         add_share(NBINS - 1, px.magnitude, UNIT_TOP - scaled + UNIT_HALF);
      end
      if (px.last_in_cell) begin
         for (int b = 0; b < NBINS; b++) begin
            bin_out.bin_number = 4'(b);
            bin_out.bin_sum    = bin_totals[b];
            bin_out.final_bin  = (b == NBINS - 1);
            expected_bins      = {expected_bins, bin_out};
            bin_totals[b] = '0;
         end
      end
   endfunction

   function automatic void check_bin(hogc_pkg::rsp_type got);
      hogc_pkg::rsp_type want;
      if (expected_bins.size() == 0) begin
         mismatches++;
         $display("%0t: bin result with none expected: bin %0d sum %0d final %0b",
                  $time, got.bin_number, got.bin_sum, got.final_bin);
         return;
      end
      want = expected_bins.pop_front();
      if (got.bin_number !== want.bin_number) begin
         mismatches++;
         $display("%0t: bin_number expected %0d actual %0d",
                  $time, want.bin_number, got.bin_number);
      end
      if (got.bin_sum !== want.bin_sum) begin
         mismatches++;
         $display("%0t: bin_sum of bin %0d expected %0d actual %0d",
                  $time, want.bin_number, want.bin_sum, got.bin_sum);
      end
      if (got.final_bin !== want.final_bin) begin
         mismatches++;
         $display("%0t: final_bin of bin %0d expected %0b actual %0b",
                  $time, want.bin_number, want.final_bin, got.final_bin);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_bins.delete();
         for (int b = 0; b < NBINS; b++) bin_totals[b] = '0;
      end else begin
         if (rsp_valid && !rsp_stall) check_bin(rsp_data);
         if (req_valid && !req_stall) predict_pixel(req_data);
      end
      bins_waiting = expected_bins.size();
   end

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Feeds pixels into the cell histogram and collects its bins. Directed pixels
// cover the angle folding, the bin edges and the magnitude extremes; a long
// cell, its first half back to back, piles up one bin; random cells follow.
// Pixels idle and bins stall at random, and the checker reports every wrong bin.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   hogc_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   hogc_pkg::rsp_type rsp_data;

   int mismatches;
   int bins_waiting;
   int pixels_sent;

   // When set, the pixel source sends back to back.
   bit steady_input;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   oriented_gradient_cell_histogram dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   hog_bin_checker scoreboard (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .mismatches   (mismatches),
      .bins_waiting (bins_waiting)
   );

   // Idle cycles before a pixel: usually none or a few, now and then a long
   // pause, so that gaps land on every stage of the accumulation pipeline.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady_input || roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Angles: mostly anywhere below 360 degrees, some right on a bin centre
   // or border (multiples of 10 degrees, give or take a Q7 step or two), and
   // some at or above 360 degrees, where the folded angle saturates.
   function automatic logic [15:0] pick_angle();
      int unsigned roll;
      int          near;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 16'($urandom_range(0, 46079));
      if (roll < 85) begin
         near = 1280 * $urandom_range(0, 36) + $urandom_range(0, 4) - 2;
         if (near < 0) near = 0;
         return 16'(near);
      end
      return 16'($urandom_range(46080, 65535));
   endfunction

   function automatic logic [15:0] pick_magnitude();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 16'($urandom_range(0, 65535));
      if (roll < 70) return 16'($urandom_range(65000, 65535));
      return 16'($urandom_range(0, 255));
   endfunction

   // Offers one pixel and holds it until the transfer happens. The valid is
   // only lowered when a gap follows, so it is never dropped and raised in
   // the same step.
   task automatic send_pixel(logic [15:0] angle, logic [15:0] mag, logic last);
      int unsigned       gap;
      hogc_pkg::req_type item;
      gap = pick_gap();
      item.angle_deg    = angle;
      item.magnitude    = mag;
      item.last_in_cell = last;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      pixels_sent++;
   endtask

   // Result side back-pressure: short stalls with the odd long one, and
   // every so often a long stretch with no stall at all.
   initial begin
      int unsigned run;
      bit          calm;
      @(posedge clock);
      forever begin
         calm = ($urandom_range(0, 9) == 0);
         run  = calm ? $urandom_range(60, 200) : $urandom_range(1, 6);
         rsp_stall <= 1'b0;
         repeat (run) @(posedge clock);
         if (!calm) begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                              : $urandom_range(1, 3);
            rsp_stall <= 1'b1;
            repeat (run) @(posedge clock);
         end
      end
   end

   initial begin
      int unsigned cell_len;
      int unsigned roll;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // First cell: the low end, the first centre and its neighbor, the second
      // centre, both sides of the high end border, and exactly 180 degrees.
      send_pixel(16'd0,     16'hFFFF, 1'b0);
      send_pixel(16'd1280,  16'd16,   1'b0);
      send_pixel(16'd1281,  16'hFFFF, 1'b0);
      send_pixel(16'd3840,  16'd1,    1'b0);
      send_pixel(16'd21759, 16'hFFFF, 1'b0);
      send_pixel(16'd21760, 16'd0,    1'b0);
      send_pixel(16'd23040, 16'hFFFF, 1'b1);

      // Second cell: angles that fold back by 180 degrees, and angles at or
      // above 360 degrees that saturate at 180 after folding.
      send_pixel(16'd23041, 16'h1234, 1'b0);
      send_pixel(16'd46079, 16'hFFFF, 1'b0);
      send_pixel(16'd46080, 16'hFFFF, 1'b0);
      send_pixel(16'hFFFF,  16'hABCD, 1'b0);
      send_pixel(16'h8000,  16'h5555, 1'b1);

      // A cell of a single pixel on a bin centre, then one of a zero-magnitude pixel.
      send_pixel(16'd11520, 16'hFFFF, 1'b1);
      send_pixel(16'd0,     16'd0,    1'b1);

      // One long cell near the centre of bin 4 with near-full magnitudes,
      // its first half sent back to back.
      steady_input = 1'b1;
      for (int i = 0; i < 24; i++) begin
         if (i == 12) steady_input = 1'b0;
         send_pixel(16'(11518 + $urandom_range(0, 4)),
                    16'hFFFF - 16'($urandom_range(0, 15)), i == 23);
      end

      // Random cells of random length; the stream always closes a cell.
      while (pixels_sent < 110) begin
         roll = $urandom_range(0, 9);
         if (roll == 0) cell_len = 1;
         else if (roll == 1) cell_len = $urandom_range(11, 24);
         else cell_len = $urandom_range(2, 10);
         steady_input = ($urandom_range(0, 4) == 0);
         for (int i = 0; i < cell_len; i++) begin
            send_pixel(pick_angle(), pick_magnitude(), i == cell_len - 1);
         end
      end
      req_valid <= 1'b0;

      // Let the checker count the last cell's bins, wait for them to drain,
      // then leave room for a stray transfer.
      @(posedge clock);
      while (bins_waiting != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (mismatches == 0 && bins_waiting == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #1000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
